>>> rtl/core/matrix3x3_inverse_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 matrix inverse
// Shared property forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_TOP_ASSERT_SVH
`define MATRIX3X3_INVERSE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define M3I_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define M3I_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/m3i_pkg.sv
// ----------------------------------------------------------------------------
// 3x3 matrix inverse package
// Fixed widths and constants shared by the datapath and its checker.
// ----------------------------------------------------------------------------
package m3i_pkg;

    // Width of each inverse element, signed Q16.16.
    localparam int INV_W = 32;

    // Fraction bits of the result format.
    localparam int SCALE_BASE = 16;

    // Saturation limits of one inverse element.
    localparam logic [INV_W-1:0] INV_MAX = {1'b0, {(INV_W-1){1'b1}}};
    localparam logic [INV_W-1:0] INV_MIN = {1'b1, {(INV_W-1){1'b0}}};

    // Edges from the accepting edge to the edge that samples done high.
    localparam int LATENCY = INV_W + 7;

endpackage

>>> rtl/core/m3i_div.sv
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per stage, with overflow detection
// for quotients that do not fit in QW bits.
// ----------------------------------------------------------------------------
module m3i_div #(
    parameter int NW = 57,
    parameter int DW = 49,
    parameter int QW = 32
) (
    input  logic          clk,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo,
    output logic          ovf
);

    localparam int HW = (NW - QW > DW) ? NW - QW : DW;

    logic [DW-1:0] rem_reg [0:QW-1];
    logic [QW-1:0] lo_reg  [0:QW-1];
    logic [DW-1:0] den_reg [0:QW-1];
    logic [QW-1:0] q_reg   [0:QW];
    logic          ovf_reg [0:QW];
    logic [HW-1:0] hi_ext;
    logic [HW-1:0] den_ext;

    // The high part of the numerator must stay below the divisor.
    assign hi_ext  = HW'(num[NW-1:QW]);
    assign den_ext = HW'(den);

    // Entry stage: overflow check and the starting partial remainder.
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= DW'(num[NW-1:QW]);
        lo_reg[0]  <= num[QW-1:0];
        den_reg[0] <= den;
        q_reg[0]   <= '0;
        ovf_reg[0] <= (hi_ext >= den_ext);
    end

    // One quotient bit per stage, most significant first.
    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [DW:0] trial;
        logic        ge;

        assign trial = {rem_reg[k], lo_reg[k][QW-1]};
        assign ge    = (trial >= {1'b0, den_reg[k]});

        always_ff @(posedge clk)
        begin
            q_reg[k+1]   <= {q_reg[k][QW-2:0], ge};
            ovf_reg[k+1] <= ovf_reg[k];
        end

        if (k < QW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[k+1] <= ge ? DW'(trial - {1'b0, den_reg[k]}) : DW'(trial);
                lo_reg[k+1]  <= {lo_reg[k][QW-2:0], 1'b0};
                den_reg[k+1] <= den_reg[k];
            end
        end
    end

    assign quo = q_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule

>>> rtl/core/matrix3x3_inverse_top.sv
// ----------------------------------------------------------------------------
// 3x3 matrix inverse, top level
// Adjugate over determinant, signed Q8.8 in, saturated Q16.16 out.
// ----------------------------------------------------------------------------
// A request is taken at every clock edge with start high; busy stays low since
// the pipeline never stalls, so one matrix per cycle is sustained. Each
// request's result appears with a one-cycle done pulse after the accepting
// edge: five stages form the products, cofactors, determinant and magnitudes,
// then nine parallel restoring dividers spend an entry stage and one stage per
// quotient bit, and a final stage saturates and registers the result. Results
// leave in request order and cannot be held off.
// A zero determinant gives singular high with zero inverse outputs.
module matrix3x3_inverse_top
    import m3i_pkg::*;
#(
    parameter int ELEMENT_WIDTH = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [ELEMENT_WIDTH-1:0] m00,
    input  logic signed [ELEMENT_WIDTH-1:0] m01,
    input  logic signed [ELEMENT_WIDTH-1:0] m02,
    input  logic signed [ELEMENT_WIDTH-1:0] m10,
    input  logic signed [ELEMENT_WIDTH-1:0] m11,
    input  logic signed [ELEMENT_WIDTH-1:0] m12,
    input  logic signed [ELEMENT_WIDTH-1:0] m20,
    input  logic signed [ELEMENT_WIDTH-1:0] m21,
    input  logic signed [ELEMENT_WIDTH-1:0] m22,
    output logic                           done,
    output logic signed [INV_W-1:0]         inv00,
    output logic signed [INV_W-1:0]         inv01,
    output logic signed [INV_W-1:0]         inv02,
    output logic signed [INV_W-1:0]         inv10,
    output logic signed [INV_W-1:0]         inv11,
    output logic signed [INV_W-1:0]         inv12,
    output logic signed [INV_W-1:0]         inv20,
    output logic signed [INV_W-1:0]         inv21,
    output logic signed [INV_W-1:0]         inv22,
    output logic signed [3*ELEMENT_WIDTH:0] det,
    output logic                           singular,
    output logic                           saturated
);

    localparam int EW = ELEMENT_WIDTH;
    localparam int PW = 2 * EW;
    localparam int CW = 2 * EW + 1;
    localparam int DW = 3 * EW + 1;
    localparam int SH = FRACTION_BITS + SCALE_BASE;
    localparam int NW = CW + SH;

    // Side information that travels beside the dividers.
    typedef struct packed {
        logic                 sing;
        logic [8:0]           neg;
        logic signed [DW-1:0] det;
    } side_t;

    logic signed [EW-1:0] a [0:2][0:2];

    logic                 v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [PW-1:0] pa_reg  [0:2][0:2];
    logic signed [PW-1:0] pb_reg  [0:2][0:2];
    logic signed [EW-1:0] a0_reg  [0:2];
    logic signed [EW-1:0] a0b_reg [0:2];
    logic signed [CW-1:0] cof_reg [0:2][0:2];
    logic signed [CW-1:0] cof3_reg [0:2][0:2];
    logic signed [CW-1:0] cof4_reg [0:2][0:2];
    logic signed [DW-1:0] dp_reg  [0:2];
    logic signed [DW-1:0] det4_reg;
    logic [NW-1:0]        num_reg [0:2][0:2];
    logic [DW-1:0]        dmag_reg;
    side_t                s5_reg;
    side_t                side_reg [0:INV_W];
    logic                 side_valid_reg [0:INV_W];
    logic [INV_W-1:0]     quo [0:2][0:2];
    logic                 ovf [0:2][0:2];
    logic [INV_W-1:0]     res [0:2][0:2];
    logic [8:0]           sat_lane;
    logic [INV_W-1:0]     out_next [0:8];
    logic [INV_W-1:0]     out_reg  [0:8];
    logic                 done_reg;
    logic                 sing_reg;
    logic                 sat_reg;
    logic signed [DW-1:0] det_reg;

    assign a[0][0] = m00; assign a[0][1] = m01; assign a[0][2] = m02;
    assign a[1][0] = m10; assign a[1][1] = m11; assign a[1][2] = m12;
    assign a[2][0] = m20; assign a[2][1] = m21; assign a[2][2] = m22;

    // The pipeline never holds a request back.
    assign busy = 1'b0;

    // Valid bits of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Stage 1 and 2: the two products of each 2x2 minor, then the cofactor.
    for (genvar i = 0; i < 3; i++)
    begin : g_row
        localparam int R0 = (i == 0) ? 1 : 0;
        localparam int R1 = (i == 2) ? 1 : 2;
        for (genvar j = 0; j < 3; j++)
        begin : g_col
            localparam int C0 = (j == 0) ? 1 : 0;
            localparam int C1 = (j == 2) ? 1 : 2;
            always_ff @(posedge clk)
            begin
                pa_reg[i][j] <= a[R0][C0] * a[R1][C1];
                pb_reg[i][j] <= a[R0][C1] * a[R1][C0];
                if (((i + j) % 2) == 0)
                begin
                    cof_reg[i][j] <= CW'(pa_reg[i][j]) - CW'(pb_reg[i][j]);
                end
                else
                begin
                    cof_reg[i][j] <= CW'(pb_reg[i][j]) - CW'(pa_reg[i][j]);
                end
                cof3_reg[i][j] <= cof_reg[i][j];
                cof4_reg[i][j] <= cof3_reg[i][j];
            end
        end
    end

    // Stage 3: first-row terms of the determinant.
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            a0_reg[j]  <= a[0][j];
            a0b_reg[j] <= a0_reg[j];
            dp_reg[j]  <= DW'(a0b_reg[j]) * DW'(cof_reg[0][j]);
        end
    end

    // Stage 4: the determinant.
    always_ff @(posedge clk)
    begin
        det4_reg <= DW'(dp_reg[0] + dp_reg[1] + dp_reg[2]);
    end

    // Stage 5: magnitudes and signs; inverse (i, j) takes cofactor (j, i).
    always_ff @(posedge clk)
    begin
        dmag_reg <= det4_reg[DW-1] ? DW'(-det4_reg) : DW'(det4_reg);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                num_reg[i][j] <= {(cof4_reg[j][i][CW-1] ? CW'(-cof4_reg[j][i])
                                                        : CW'(cof4_reg[j][i])),
                                  {SH{1'b0}}};
                s5_reg.neg[i*3+j] <= cof4_reg[j][i][CW-1] ^ det4_reg[DW-1];
            end
        end
        s5_reg.det  <= det4_reg;
        s5_reg.sing <= (det4_reg == '0);
    end

    // Nine divider lanes.
    for (genvar i = 0; i < 3; i++)
    begin : g_div_row
        for (genvar j = 0; j < 3; j++)
        begin : g_div_col
            m3i_div #(
                .NW (NW),
                .DW (DW),
                .QW (INV_W)
            ) u_div (
                .clk (clk),
                .num (num_reg[i][j]),
                .den (dmag_reg),
                .quo (quo[i][j]),
                .ovf (ovf[i][j])
            );
        end
    end

    // Valid bits delayed to match the dividers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= INV_W; k++)
            begin
                side_valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            side_valid_reg[0] <= v5_reg;
            for (int k = 1; k <= INV_W; k++)
            begin
                side_valid_reg[k] <= side_valid_reg[k-1];
            end
        end
    end

    // Side information delayed to match the dividers.
    always_ff @(posedge clk)
    begin
        side_reg[0] <= s5_reg;
        for (int k = 1; k <= INV_W; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    // Sign, saturation and the singular case.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                sat_lane[i*3+j] = 1'b0;
                if (side_reg[INV_W].sing)
                begin
                    res[i][j] = '0;
                end
                else if (!side_reg[INV_W].neg[i*3+j])
                begin
                    if (ovf[i][j] || quo[i][j][INV_W-1])
                    begin
                        res[i][j] = INV_MAX;
                        sat_lane[i*3+j] = 1'b1;
                    end
                    else
                    begin
                        res[i][j] = quo[i][j];
                    end
                end
                else
                begin
                    if (ovf[i][j] || (quo[i][j][INV_W-1] && (|quo[i][j][INV_W-2:0])))
                    begin
                        res[i][j] = INV_MIN;
                        sat_lane[i*3+j] = 1'b1;
                    end
                    else
                    begin
                        res[i][j] = ~quo[i][j] + 1'b1;
                    end
                end
                out_next[i*3+j] = res[i][j];
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= side_valid_reg[INV_W];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            out_reg[k] <= out_next[k];
        end
        det_reg  <= side_reg[INV_W].det;
        sing_reg <= side_reg[INV_W].sing;
        sat_reg  <= |sat_lane;
    end

    assign done      = done_reg;
    assign inv00     = out_reg[0];
    assign inv01     = out_reg[1];
    assign inv02     = out_reg[2];
    assign inv10     = out_reg[3];
    assign inv11     = out_reg[4];
    assign inv12     = out_reg[5];
    assign inv20     = out_reg[6];
    assign inv21     = out_reg[7];
    assign inv22     = out_reg[8];
    assign det       = det_reg;
    assign singular  = sing_reg;
    assign saturated = sat_reg;

endmodule

>>> rtl/core/m3i_checker.sv
// ----------------------------------------------------------------------------
// 3x3 matrix inverse port checker
// Watches the top level's ports for latency and singular-case behavior.
// ----------------------------------------------------------------------------
`include "matrix3x3_inverse_top_assert.svh"

module m3i_checker
    import m3i_pkg::*;
#(
    parameter int DW = 49
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic [INV_W-1:0]     inv00,
    input logic [INV_W-1:0]     inv11,
    input logic [INV_W-1:0]     inv22,
    input logic [DW-1:0]        det,
    input logic                 singular,
    input logic                 saturated
);

    // Every accepted request produces its result after the fixed latency.
    `M3I_ASSERT_IMP(a_latency, clk, rst_n, start && !busy, ##(LATENCY) done, "missing result")

    // No result appears without a request that long ago.
    `M3I_ASSERT_IMP(a_no_spurious, clk, rst_n, done, $past(start && !busy, LATENCY),
                    "result without request")

    // A singular result carries zero determinant and a zero inverse diagonal, no clamp.
    `M3I_ASSERT_IMP(a_singular, clk, rst_n, done && singular,
                    det == '0 && inv00 == '0 && inv11 == '0 && inv22 == '0 && !saturated,
                    "singular result not cleared")

    // A non-singular result has a nonzero determinant.
    `M3I_ASSERT_IMP(a_det_nonzero, clk, rst_n, done && !singular, det != '0,
                    "zero determinant not flagged")

endmodule

bind matrix3x3_inverse_top m3i_checker #(
    .DW (3 * ELEMENT_WIDTH + 1)
) u_m3i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .inv00     (inv00),
    .inv11     (inv11),
    .inv22     (inv22),
    .det       (det),
    .singular  (singular),
    .saturated (saturated)
);
